// ===== rtl/bcpm_pkg.sv =====
package bcpm_pkg;

  // Field and datapath widths.
  localparam int ValW   = 16;  // every input field
  localparam int RawW   = 18;  // wheel sum minus goal speed
  localparam int NumW   = 28;  // 4*e + 256*raw, signed
  localparam int MagW   = 27;  // magnitude of that numerator
  localparam int EW     = 26;  // filtered speed error, signed Q.8
  localparam int QuoW   = 25;  // magnitude of the filtered error
  localparam int IntW   = 24;  // clamped speed integral, signed Q.8
  localparam int SumW   = 27;  // integral plus error before the clamp
  localparam int MulW   = 29;  // signed operands of the shared multiplier
  localparam int ProdW  = 2 * MulW;
  localparam int AccW   = 44;  // loop sum in Q.16
  localparam int ShpW   = 28;  // shaped loop output in Q.16
  localparam int MixW   = 30;  // sum of three shaped outputs
  localparam int DutyW  = 12;
  localparam int IlimW  = 23;
  localparam int OlimW  = 10;
  localparam int InW    = 7 * ValW;
  localparam int OutW   = 32;

  // Division by five through a reciprocal: floor(n/5) = (n*Recip) >> RecipK
  // holds exactly for every n below 2**27.
  localparam int RecipK = 30;
  localparam logic [MulW-2:0] Recip = 28'd214748365;

  // Shaping and tilt constants.
  localparam int HalfQ   = 32768;
  localparam int OneQ    = 65536;
  localparam int TiltLim = 60 * 256;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BALANCE_OFFSET = 3'd0,
    REG_STAND_KP       = 3'd1,
    REG_STAND_KD       = 3'd2,
    REG_SPEED_KP       = 3'd3,
    REG_SPEED_KI       = 3'd4,
    REG_STEER_KP       = 3'd5,
    REG_INTEGRAL_LIMIT = 3'd6,
    REG_OUTPUT_LIMIT   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [ValW-1:0] balance_offset;
    logic [ValW-1:0]        stand_kp;
    logic [ValW-1:0]        stand_kd;
    logic [ValW-1:0]        speed_kp;
    logic [ValW-1:0]        speed_ki;
    logic [ValW-1:0]        steer_kp;
    logic [IlimW-1:0]       integral_limit;
    logic [OlimW-1:0]       output_limit;
  } cfg_t;

  // One wheel command after the mixer.
  typedef struct packed {
    logic             fwd;
    logic [DutyW-1:0] duty;
  } drv_t;

  // Sequencer steps of one control tick.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ERR,
    ST_SKP,
    ST_SKI,
    ST_SSUM,
    ST_SSHP,
    ST_UKD,
    ST_USUM,
    ST_USHP,
    ST_STR,
    ST_RSHP,
    ST_MIX
  } st_e;

endpackage

// ===== rtl/balance_cascade_pid_mixer.sv =====
// Channel       Dir  Handshake                Payload
// s_axis        in   s_axis_tvalid/tready     one control tick, seven 16-bit fields
// m_axis        out  m_axis_tvalid/tready     direction and duty for both wheels
// cfg           in   cfg_valid_i/cfg_ready_o  register index and write data
//
// The input is taken in the idle state, then thirteen sequencer steps share one
// registered multiplier; no new tick is taken before the sequencer returns to idle.
// Reset (asynchronous, active low) restores the register defaults and clears
// the filtered speed error and the speed integral.
// A stalled result waits in the output register; the next tick is taken
// meanwhile and holds in its last step until that register frees up.
module balance_cascade_pid_mixer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Fields from bit 0 up: pitch, pitch_rate, wheel_speed_left,
  // wheel_speed_right, target_speed, heading, target_heading.
  input  logic [bcpm_pkg::InW-1:0]         s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: left_forward, left_duty, right_forward,
  // right_duty, then zero fill.
  output logic [bcpm_pkg::OutW-1:0]        m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [2:0]                       cfg_index_i,
  input  logic [bcpm_pkg::IlimW-1:0]       cfg_data_i
);

  bcpm_pkg::cfg_t cfg;
  logic signed [bcpm_pkg::MulW-1:0]  mul_a, mul_b;
  logic signed [bcpm_pkg::ProdW-1:0] prod;

  bcpm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bcpm_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  bcpm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .prod_i      (prod)
  );

`ifndef SYNTHESIS
  // The sequencer is busy right after an input transfer.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while the sequencer was busy");

  // A new result cannot appear the cycle after a tick is taken.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared before the tick was worked through");

  // A zero command always drives forward.
  a_left_zero_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[12:1] == 12'd0) |-> m_axis_tdata[0])
    else $error("left wheel reversed with zero duty");

  a_right_zero_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[25:14] == 12'd0) |-> m_axis_tdata[13])
    else $error("right wheel reversed with zero duty");
`endif

endmodule

// ===== rtl/bcpm_cfg.sv =====
module bcpm_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [2:0]                      cfg_index_i,
  input  logic [bcpm_pkg::IlimW-1:0]      cfg_data_i,
  output bcpm_pkg::cfg_t                  cfg_o
);

  bcpm_pkg::cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register file with the documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.balance_offset <= 16'sd717;
      cfg_q.stand_kp       <= 16'd6682;
      cfg_q.stand_kd       <= 16'd0;
      cfg_q.speed_kp       <= 16'd282;
      cfg_q.speed_ki       <= 16'd0;
      cfg_q.steer_kp       <= 16'd474;
      cfg_q.integral_limit <= 23'd69818;
      cfg_q.output_limit   <= 10'd300;
    end else if (cfg_valid_i) begin
      unique case (bcpm_pkg::cfg_idx_e'(cfg_index_i))
        bcpm_pkg::REG_BALANCE_OFFSET: begin
          cfg_q.balance_offset <= $signed(cfg_data_i[bcpm_pkg::ValW-1:0]);
        end
        bcpm_pkg::REG_STAND_KP: cfg_q.stand_kp <= cfg_data_i[bcpm_pkg::ValW-1:0];
        bcpm_pkg::REG_STAND_KD: cfg_q.stand_kd <= cfg_data_i[bcpm_pkg::ValW-1:0];
        bcpm_pkg::REG_SPEED_KP: cfg_q.speed_kp <= cfg_data_i[bcpm_pkg::ValW-1:0];
        bcpm_pkg::REG_SPEED_KI: cfg_q.speed_ki <= cfg_data_i[bcpm_pkg::ValW-1:0];
        bcpm_pkg::REG_STEER_KP: cfg_q.steer_kp <= cfg_data_i[bcpm_pkg::ValW-1:0];
        bcpm_pkg::REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data_i;
        bcpm_pkg::REG_OUTPUT_LIMIT: begin
          cfg_q.output_limit <= cfg_data_i[bcpm_pkg::OlimW-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/bcpm_mul.sv =====
module bcpm_mul (
  input  logic                                clk_i,
  input  logic signed [bcpm_pkg::MulW-1:0]    a_i,
  input  logic signed [bcpm_pkg::MulW-1:0]    b_i,
  output logic signed [bcpm_pkg::ProdW-1:0]   prod_o
);

  logic signed [bcpm_pkg::ProdW-1:0] prod_q;

  // Shared signed multiplier with a registered product.
  always_ff @(posedge clk_i) begin
    prod_q <= bcpm_pkg::ProdW'(a_i) * bcpm_pkg::ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/bcpm_seq.sv =====
module bcpm_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bcpm_pkg::cfg_t                     cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bcpm_pkg::InW-1:0]           in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bcpm_pkg::OutW-1:0]          out_data_o,
  output logic signed [bcpm_pkg::MulW-1:0]   mul_a_o,
  output logic signed [bcpm_pkg::MulW-1:0]   mul_b_o,
  input  logic signed [bcpm_pkg::ProdW-1:0]  prod_i
);

  localparam int ValW = bcpm_pkg::ValW;
  localparam int AccW = bcpm_pkg::AccW;
  localparam int ShpW = bcpm_pkg::ShpW;
  localparam int MixW = bcpm_pkg::MixW;
  localparam int MulW = bcpm_pkg::MulW;
  localparam int EW   = bcpm_pkg::EW;
  localparam int IntW = bcpm_pkg::IntW;
  localparam int SumW = bcpm_pkg::SumW;
  localparam int NumW = bcpm_pkg::NumW;
  localparam int MagW = bcpm_pkg::MagW;
  localparam int RawW = bcpm_pkg::RawW;
  localparam int QuoW = bcpm_pkg::QuoW;

  // Snap small nonzero outputs to plus or minus one, then clamp to the limit.
  function automatic logic signed [ShpW-1:0] shape(input logic signed [AccW-1:0] q,
                                                   input logic [bcpm_pkg::OlimW-1:0] olim);
    logic signed [AccW-1:0] lim;
    logic signed [AccW-1:0] half_p;
    logic signed [AccW-1:0] one_p;
    logic signed [AccW-1:0] r;
    lim    = $signed({{(AccW - bcpm_pkg::OlimW - 16){1'b0}}, olim, 16'h0000});
    half_p = AccW'(bcpm_pkg::HalfQ);
    one_p  = AccW'(bcpm_pkg::OneQ);
    r      = q;
    if (q > 0 && q <= half_p) begin
      r = one_p;
    end else if (q < 0 && q >= -half_p) begin
      r = -one_p;
    end
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r[ShpW-1:0];
  endfunction

  // Truncate a Q.16 command toward zero and split it into direction and duty.
  function automatic bcpm_pkg::drv_t drive(input logic signed [MixW-1:0] q);
    logic signed [MixW-1:0] adj;
    logic signed [MixW-1:0] n;
    logic signed [MixW-1:0] mag;
    bcpm_pkg::drv_t         d;
    adj    = q + (q[MixW-1] ? MixW'(bcpm_pkg::OneQ - 1) : MixW'(0));
    n      = adj >>> 16;
    mag    = n[MixW-1] ? -n : n;
    d.fwd  = ~n[MixW-1];
    d.duty = mag[bcpm_pkg::DutyW-1:0];
    return d;
  endfunction

  bcpm_pkg::st_e state_q, state_d;

  // Latched input item.
  logic signed [ValW-1:0] pitch_q, rate_q, vl_q, vr_q, goal_q, head_q, ghead_q;

  // Loop state that persists across ticks.
  logic signed [EW-1:0]   fe_q;
  logic signed [IntW-1:0] si_q;

  // Per-tick working registers.
  logic                   num_neg_q;
  logic [MagW-1:0]        mag_q;
  logic signed [EW-1:0]   e_q;
  logic signed [IntW-1:0] integ_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [ShpW-1:0] spd_q, stn_q, str_q;

  logic                   out_valid_q;
  logic [bcpm_pkg::OutW-1:0] out_data_q;

  logic accept, out_free;
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Speed error numerator: 4*e + 256*(left + right - goal).
  logic signed [RawW-1:0] raw;
  logic signed [NumW-1:0] num, num_abs;
  assign raw     = RawW'(vl_q) + RawW'(vr_q) - RawW'(goal_q);
  assign num     = (NumW'(fe_q) <<< 2) + (NumW'(raw) <<< 8);
  assign num_abs = num[NumW-1] ? -num : num;

  // Quotient by five from the reciprocal product, signed back.
  logic [QuoW-1:0]        quo;
  logic signed [EW-1:0]   quo_s, e_new;
  assign quo   = prod_i[bcpm_pkg::RecipK +: QuoW];
  assign quo_s = $signed({1'b0, quo});
  assign e_new = num_neg_q ? -quo_s : quo_s;

  // Integral update with the symmetric clamp.
  logic signed [SumW-1:0] isum, ilim_s, iclamp;
  assign isum   = SumW'(si_q) + SumW'(e_new);
  assign ilim_s = $signed({{(SumW - bcpm_pkg::IlimW){1'b0}}, cfg_i.integral_limit});
  always_comb begin
    if (isum > ilim_s) begin
      iclamp = ilim_s;
    end else if (isum < -ilim_s) begin
      iclamp = -ilim_s;
    end else begin
      iclamp = isum;
    end
  end

  logic tilt;
  assign tilt = (pitch_q > ValW'(bcpm_pkg::TiltLim)) || (pitch_q < -ValW'(bcpm_pkg::TiltLim));

  // Loop operands.
  logic signed [ValW:0] up_err, st_err;
  assign up_err = (ValW + 1)'(cfg_i.balance_offset) - (ValW + 1)'(pitch_q);
  assign st_err = (ValW + 1)'(ghead_q) - (ValW + 1)'(head_q);

  // Mixer.
  logic signed [MixW-1:0] base, left_q16, right_q16;
  bcpm_pkg::drv_t drv_l, drv_r;
  assign base      = MixW'(stn_q) + MixW'(spd_q);
  assign left_q16  = base - MixW'(str_q);
  assign right_q16 = base + MixW'(str_q);
  assign drv_l     = drive(left_q16);
  assign drv_r     = drive(right_q16);

  // Next step and multiplier operand selection.
  always_comb begin
    state_d = state_q;
    mul_a_o = '0;
    mul_b_o = '0;
    unique case (state_q)
      bcpm_pkg::ST_IDLE: if (in_valid_i) state_d = bcpm_pkg::ST_PREP;
      bcpm_pkg::ST_PREP: state_d = bcpm_pkg::ST_DIV;
      bcpm_pkg::ST_DIV: begin
        mul_a_o = $signed({{(MulW - MagW){1'b0}}, mag_q});
        mul_b_o = $signed({1'b0, bcpm_pkg::Recip});
        state_d = bcpm_pkg::ST_ERR;
      end
      bcpm_pkg::ST_ERR: state_d = bcpm_pkg::ST_SKP;
      bcpm_pkg::ST_SKP: begin
        mul_a_o = $signed({{(MulW - ValW){1'b0}}, cfg_i.speed_kp});
        mul_b_o = MulW'(e_q);
        state_d = bcpm_pkg::ST_SKI;
      end
      bcpm_pkg::ST_SKI: begin
        mul_a_o = $signed({{(MulW - ValW){1'b0}}, cfg_i.speed_ki});
        mul_b_o = MulW'(integ_q);
        state_d = bcpm_pkg::ST_SSUM;
      end
      bcpm_pkg::ST_SSUM: state_d = bcpm_pkg::ST_SSHP;
      bcpm_pkg::ST_SSHP: begin
        mul_a_o = $signed({{(MulW - ValW){1'b0}}, cfg_i.stand_kp});
        mul_b_o = MulW'(up_err);
        state_d = bcpm_pkg::ST_UKD;
      end
      bcpm_pkg::ST_UKD: begin
        mul_a_o = $signed({{(MulW - ValW){1'b0}}, cfg_i.stand_kd});
        mul_b_o = MulW'(rate_q);
        state_d = bcpm_pkg::ST_USUM;
      end
      bcpm_pkg::ST_USUM: state_d = bcpm_pkg::ST_USHP;
      bcpm_pkg::ST_USHP: begin
        mul_a_o = $signed({{(MulW - ValW){1'b0}}, cfg_i.steer_kp});
        mul_b_o = MulW'(st_err);
        state_d = bcpm_pkg::ST_STR;
      end
      bcpm_pkg::ST_STR:  state_d = bcpm_pkg::ST_RSHP;
      bcpm_pkg::ST_RSHP: state_d = bcpm_pkg::ST_MIX;
      bcpm_pkg::ST_MIX:  if (out_free) state_d = bcpm_pkg::ST_IDLE;
      default:           state_d = bcpm_pkg::ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == bcpm_pkg::ST_IDLE);

  // State register, persistent loop state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcpm_pkg::ST_IDLE;
      fe_q        <= '0;
      si_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == bcpm_pkg::ST_ERR) begin
        fe_q <= e_new;
        si_q <= tilt ? IntW'(0) : iclamp[IntW-1:0];
      end
      if (state_q == bcpm_pkg::ST_MIX && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working datapath registers, loaded step by step.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pitch_q <= $signed(in_data_i[0*ValW +: ValW]);
      rate_q  <= $signed(in_data_i[1*ValW +: ValW]);
      vl_q    <= $signed(in_data_i[2*ValW +: ValW]);
      vr_q    <= $signed(in_data_i[3*ValW +: ValW]);
      goal_q  <= $signed(in_data_i[4*ValW +: ValW]);
      head_q  <= $signed(in_data_i[5*ValW +: ValW]);
      ghead_q <= $signed(in_data_i[6*ValW +: ValW]);
    end
    case (state_q)
      bcpm_pkg::ST_PREP: begin
        num_neg_q <= num[NumW-1];
        mag_q     <= num_abs[MagW-1:0];
      end
      bcpm_pkg::ST_ERR: begin
        e_q     <= e_new;
        integ_q <= iclamp[IntW-1:0];
      end
      bcpm_pkg::ST_SKI:  acc_q <= AccW'(prod_i);
      bcpm_pkg::ST_SSUM: acc_q <= acc_q + AccW'(prod_i);
      bcpm_pkg::ST_SSHP: spd_q <= shape(acc_q, cfg_i.output_limit);
      bcpm_pkg::ST_UKD:  acc_q <= AccW'(prod_i);
      bcpm_pkg::ST_USUM: acc_q <= acc_q + AccW'(prod_i);
      bcpm_pkg::ST_USHP: stn_q <= shape(acc_q, cfg_i.output_limit);
      bcpm_pkg::ST_STR:  acc_q <= AccW'(prod_i);
      bcpm_pkg::ST_RSHP: str_q <= shape(acc_q, cfg_i.output_limit);
      default: ;
    endcase
    if (state_q == bcpm_pkg::ST_MIX && out_free) begin
      out_data_q <= {{(bcpm_pkg::OutW - 2 * (bcpm_pkg::DutyW + 1)){1'b0}},
                     drv_r.duty, drv_r.fwd, drv_l.duty, drv_l.fwd};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam longint UnitQ16   = 65536;
  localparam longint HalfQ16   = 32768;
  localparam longint TiltRaw   = 60 * 256;
  localparam int     IdleLimit = 2000;
  localparam int     HoldLen   = 400;

  // One control tick, pitch in the lowest bits.
  typedef struct packed {
    logic signed [15:0] tgt_head;
    logic signed [15:0] head;
    logic signed [15:0] goal;
    logic signed [15:0] wr;
    logic signed [15:0] wl;
    logic signed [15:0] rate;
    logic signed [15:0] pitch;
  } ctl_tick_t;

  // Wheel command as it appears on the output bus.
  typedef struct packed {
    logic [5:0]  fill;
    logic [11:0] duty_r;
    logic        fwd_r;
    logic [11:0] duty_l;
    logic        fwd_l;
  } wheel_cmd_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic [111:0] s_axis_tdata  = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i   = '0;
  logic [22:0]  cfg_data_i    = '0;

  // Register copies and loop state of the controller, at their reset values.
  longint bal_offset    = 717;
  longint gain_stand_kp = 6682;
  longint gain_stand_kd = 0;
  longint gain_speed_kp = 282;
  longint gain_speed_ki = 0;
  longint gain_steer_kp = 474;
  longint lim_integ     = 69818;
  longint lim_out       = 300;
  int     filt_err      = 0;
  int     spd_integ     = 0;

  ctl_tick_t  pending_ticks[$];
  wheel_cmd_t wheel_cmds_due[$];

  ctl_tick_t cur_tick;
  logic      load_tick;
  int        burst_left   = 0;
  int        gap_left     = 0;
  int        ticks_taken  = 0;
  int        results_seen = 0;
  int        hold_left    = 0;
  int        stall_mode   = 0;
  int        mode_cycles  = 0;
  logic      rdy_next;
  logic [7:0] stall_pat   = 8'hff;
  int        mismatches   = 0;
  int        settings     = 0;
  int        idle_cycles  = 0;

  balance_cascade_pid_mixer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Snap small nonzero loop outputs to one unit, then saturate.
  function automatic longint shape_loop(longint q);
    longint lim;
    lim = lim_out * UnitQ16;
    if (q > 0 && q <= HalfQ16) q = UnitQ16;
    else if (q < 0 && q >= -HalfQ16) q = -UnitQ16;
    if (q > lim) q = lim;
    else if (q < -lim) q = -lim;
    return q;
  endfunction

  // Truncate a Q.16 command toward zero and split it into direction and duty.
  function automatic logic [12:0] split_drive(longint q);
    longint n;
    longint mag;
    logic   fwd;
    n   = q / UnitQ16;
    fwd = (n >= 0);
    mag = fwd ? n : -n;
    return {fwd, mag[11:0]};
  endfunction

  // Run the three loops for one tick, update the speed state and mix the wheels.
  function automatic wheel_cmd_t mix_wheel_command(ctl_tick_t t);
    longint pitch, raw, err, integ, speed_q, stand_q, steer_q;
    wheel_cmd_t cmd;
    pitch = $signed(t.pitch);
    raw   = $signed(t.wl);
    raw   = raw + $signed(t.wr);
    raw   = raw - $signed(t.goal);
    err   = (longint'(filt_err) * 4 + raw * 256) / 5;
    filt_err = int'(err);
    integ = longint'(spd_integ) + err;
    if (integ > lim_integ) integ = lim_integ;
    else if (integ < -lim_integ) integ = -lim_integ;
    speed_q = shape_loop(gain_speed_kp * err + gain_speed_ki * integ);
    // A tipped-over robot drops its accumulated speed integral.
    if (pitch > TiltRaw || pitch < -TiltRaw) integ = 0;
    spd_integ = int'(integ);
    stand_q = $signed(t.rate);
    stand_q = shape_loop(gain_stand_kp * (bal_offset - pitch) + gain_stand_kd * stand_q);
    steer_q = $signed(t.tgt_head);
    steer_q = steer_q - $signed(t.head);
    steer_q = shape_loop(gain_steer_kp * steer_q);
    cmd = '0;
    {cmd.fwd_l, cmd.duty_l} = split_drive(stand_q + speed_q - steer_q);
    {cmd.fwd_r, cmd.duty_r} = split_drive(stand_q + speed_q + steer_q);
    return cmd;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on result %0d, %s: got %0d, expected %0d",
             $time, results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_wheels(wheel_cmd_t got);
    wheel_cmd_t want;
    if (wheel_cmds_due.size() == 0) begin
      report_mismatch("result with nothing pending", got, 0);
    end else begin
      want = wheel_cmds_due.pop_front();
      if (got.fwd_l !== want.fwd_l) report_mismatch("left_forward", got.fwd_l, want.fwd_l);
      if (got.duty_l !== want.duty_l) report_mismatch("left_duty", got.duty_l, want.duty_l);
      if (got.fwd_r !== want.fwd_r) report_mismatch("right_forward", got.fwd_r, want.fwd_r);
      if (got.duty_r !== want.duty_r) report_mismatch("right_duty", got.duty_r, want.duty_r);
      if (got.fill !== want.fill) report_mismatch("zero fill", got.fill, want.fill);
    end
  endtask

  function automatic ctl_tick_t make_tick(int p, int r, int wl, int wr, int g, int h, int gh);
    ctl_tick_t t;
    t.pitch    = p[15:0];
    t.rate     = r[15:0];
    t.wl       = wl[15:0];
    t.wr       = wr[15:0];
    t.goal     = g[15:0];
    t.head     = h[15:0];
    t.tgt_head = gh[15:0];
    return t;
  endfunction

  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // Mostly plausible balancing ticks, with some noise and some extremes.
  function automatic ctl_tick_t rand_tick();
    ctl_tick_t t;
    logic [127:0] noise;
    int kind, pitch, lean, base, h;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      noise = {$urandom(), $urandom(), $urandom(), $urandom()};
      t = noise[111:0];
    end else if (kind == 1) begin
      t = make_tick(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                    pick_extreme(), pick_extreme(), pick_extreme());
    end else begin
      if ($urandom_range(0, 7) == 0) begin
        lean = 15359 + $urandom_range(0, 2);
        if ($urandom_range(0, 1)) lean += $urandom_range(0, 8000);
        pitch = $urandom_range(0, 1) ? lean : -lean;
      end else begin
        pitch = int'(bal_offset) + spread(2048);
      end
      base = spread(150);
      h    = spread(20000);
      t = make_tick(pitch, spread(4096), base + spread(40), base + spread(40), spread(300),
                    h, h + spread(1500));
    end
    return t;
  endfunction

  // Gain word with random bits above the register width.
  function automatic logic [22:0] gain_word();
    logic [6:0]  junk;
    logic [15:0] gain;
    junk = 7'($urandom());
    gain = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2000));
    return {junk, gain};
  endfunction

  task automatic set_reg(bcpm_pkg::cfg_idx_e idx, logic [22:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      bcpm_pkg::REG_BALANCE_OFFSET: bal_offset = $signed(val[15:0]);
      bcpm_pkg::REG_STAND_KP:       gain_stand_kp = val[15:0];
      bcpm_pkg::REG_STAND_KD:       gain_stand_kd = val[15:0];
      bcpm_pkg::REG_SPEED_KP:       gain_speed_kp = val[15:0];
      bcpm_pkg::REG_SPEED_KI:       gain_speed_ki = val[15:0];
      bcpm_pkg::REG_STEER_KP:       gain_steer_kp = val[15:0];
      bcpm_pkg::REG_INTEGRAL_LIMIT: lim_integ = val;
      default:                      lim_out = val[9:0];
    endcase
  endtask

  // Idle means nothing queued, nothing offered and every result returned.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || s_axis_tvalid || wheel_cmds_due.size() != 0);
  endtask

  task automatic feed_ticks(int n);
    @(negedge clk_i);
    repeat (n) pending_ticks.push_back(rand_tick());
    settings++;
    wait_drained();
  endtask

  // Input driver: bursts of ticks separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      load_tick = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        wheel_cmds_due.push_back(mix_wheel_command(cur_tick));
        ticks_taken++;
        if (burst_left > 0) burst_left--;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ticks.size() != 0) begin
          cur_tick  = pending_ticks.pop_front();
          load_tick = 1'b1;
        end
        s_axis_tvalid <= load_tick;
        if (load_tick) s_axis_tdata <= cur_tick;
      end
    end
  end

  // Output monitor: checks each transfer and stalls at random or on a changing pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_wheels(wheel_cmd_t'(m_axis_tdata));
        results_seen++;
        // Long hold-off so the block backs up into its input.
        if (results_seen == 150 || results_seen == 600) hold_left = HoldLen;
      end
      mode_cycles++;
      if (mode_cycles % 64 == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_pat  = 8'($urandom()) | 8'h01;
      end
      stall_pat = {stall_pat[6:0], stall_pat[7]};
      if (hold_left > 0) begin
        hold_left--;
        rdy_next = 1'b0;
      end else begin
        case (stall_mode)
          0: rdy_next = 1'b1;
          1: rdy_next = ($urandom_range(0, 2) != 0);
          default: rdy_next = stall_pat[0];
        endcase
      end
      m_axis_tready <= rdy_next;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[%0t] no transfer for %0d cycles", $time, IdleLimit);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed ticks under the reset settings.
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    pending_ticks.push_back(make_tick(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    pending_ticks.push_back(make_tick(32767, -32768, 32767, 32767, -32768, -32768, 32767));
    // Pitch right at and just past the tilt threshold.
    pending_ticks.push_back(make_tick(15360, 0, 3, 2, 0, 0, 0));
    pending_ticks.push_back(make_tick(15361, 0, 3, 2, 0, 0, 0));
    pending_ticks.push_back(make_tick(-15360, 0, -3, -2, 0, 0, 0));
    pending_ticks.push_back(make_tick(-15361, 0, -3, -2, 0, 0, 0));
    // Loop outputs below half a unit snap to plus or minus one.
    pending_ticks.push_back(make_tick(716, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(718, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(717, 0, 0, 0, 0, 1, 0));
    pending_ticks.push_back(make_tick(717, 0, 0, 0, 0, 0, 1));
    pending_ticks.push_back(make_tick(717, 0, 1, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(717, 0, 0, 0, 1, 0, 0));
    repeat (8) pending_ticks.push_back(make_tick(pick_extreme(), pick_extreme(),
        pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()));
    feed_ticks(100);

    // Moderate gains with integral action.
    set_reg(bcpm_pkg::REG_BALANCE_OFFSET, 23'd0);
    set_reg(bcpm_pkg::REG_STAND_KP, 23'd6682);
    set_reg(bcpm_pkg::REG_STAND_KD, 23'd300);
    set_reg(bcpm_pkg::REG_SPEED_KP, 23'd282);
    set_reg(bcpm_pkg::REG_SPEED_KI, 23'd1000);
    set_reg(bcpm_pkg::REG_STEER_KP, 23'd474);
    set_reg(bcpm_pkg::REG_INTEGRAL_LIMIT, 23'd5000);
    set_reg(bcpm_pkg::REG_OUTPUT_LIMIT, 23'd1000);
    feed_ticks(150);

    // Every register at its top value.
    set_reg(bcpm_pkg::REG_BALANCE_OFFSET, 23'h007fff);
    set_reg(bcpm_pkg::REG_STAND_KP, 23'h00ffff);
    set_reg(bcpm_pkg::REG_STAND_KD, 23'h00ffff);
    set_reg(bcpm_pkg::REG_SPEED_KP, 23'h00ffff);
    set_reg(bcpm_pkg::REG_SPEED_KI, 23'h00ffff);
    set_reg(bcpm_pkg::REG_STEER_KP, 23'h00ffff);
    set_reg(bcpm_pkg::REG_INTEGRAL_LIMIT, 23'h7fffff);
    set_reg(bcpm_pkg::REG_OUTPUT_LIMIT, 23'd1023);
    feed_ticks(100);

    // Zero integral limit: the integral stays at zero whatever its gain.
    set_reg(bcpm_pkg::REG_BALANCE_OFFSET, 23'h008000);
    set_reg(bcpm_pkg::REG_STAND_KP, 23'd0);
    set_reg(bcpm_pkg::REG_STAND_KD, 23'd0);
    set_reg(bcpm_pkg::REG_SPEED_KP, 23'd0);
    set_reg(bcpm_pkg::REG_STEER_KP, 23'd0);
    set_reg(bcpm_pkg::REG_INTEGRAL_LIMIT, 23'd0);
    set_reg(bcpm_pkg::REG_OUTPUT_LIMIT, 23'd1000);
    feed_ticks(40);

    // Zero output limit wipes out even the snapped outputs.
    set_reg(bcpm_pkg::REG_STAND_KP, 23'd1);
    set_reg(bcpm_pkg::REG_SPEED_KP, 23'd3);
    set_reg(bcpm_pkg::REG_STEER_KP, 23'd2);
    set_reg(bcpm_pkg::REG_OUTPUT_LIMIT, 23'd0);
    feed_ticks(30);

    // Unit-sized gains so most loop outputs hit the snap.
    set_reg(bcpm_pkg::REG_BALANCE_OFFSET, 23'd256);
    set_reg(bcpm_pkg::REG_STAND_KP, 23'd2);
    set_reg(bcpm_pkg::REG_STAND_KD, 23'd1);
    set_reg(bcpm_pkg::REG_SPEED_KP, 23'd1);
    set_reg(bcpm_pkg::REG_SPEED_KI, 23'd1);
    set_reg(bcpm_pkg::REG_STEER_KP, 23'd3);
    set_reg(bcpm_pkg::REG_INTEGRAL_LIMIT, 23'd300);
    set_reg(bcpm_pkg::REG_OUTPUT_LIMIT, 23'd1);
    feed_ticks(100);

    // Random settings, with junk above the width of each register narrower than the bus.
    repeat (4) begin
      set_reg(bcpm_pkg::REG_BALANCE_OFFSET, 23'($urandom()));
      set_reg(bcpm_pkg::REG_STAND_KP, gain_word());
      set_reg(bcpm_pkg::REG_STAND_KD, gain_word());
      set_reg(bcpm_pkg::REG_SPEED_KP, gain_word());
      set_reg(bcpm_pkg::REG_SPEED_KI, gain_word());
      set_reg(bcpm_pkg::REG_STEER_KP, gain_word());
      set_reg(bcpm_pkg::REG_INTEGRAL_LIMIT, ($urandom_range(0, 2) == 0) ? 23'($urandom()) :
                                            23'($urandom_range(0, 200000)));
      set_reg(bcpm_pkg::REG_OUTPUT_LIMIT, {13'($urandom()), 10'($urandom_range(0, 1023))});
      feed_ticks(75);
    end

    // Let any stray result show up before the verdict.
    repeat (40) @(posedge clk_i);
    $display("Ran %0d control ticks over %0d register settings and checked %0d results,",
             ticks_taken, settings, results_seen);
    $display("covering tilt cutoff, output snap, saturation and zero limits: %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
